// ===== sv/cfwsm_pkg.sv =====
// Package for the case-fold window string matcher: codes, constants and shared types.
`timescale 1ns / 1ps
package cfwsm_pkg;

  localparam logic [7:0]  NEWLINE_BYTE = 8'd10;
  localparam logic [7:0]  BINARY_BYTE  = 8'd26;
  localparam logic [7:0]  CASE_OFFSET  = 8'd32;
  localparam logic [7:0]  UPPER_FIRST  = 8'h41;
  localparam logic [7:0]  UPPER_LAST   = 8'h5A;
  localparam logic [31:0] LINE_MAX     = 32'hFFFF_FFFF;

  localparam int REG_BYTES   = 16;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 64;
  localparam int LEN_W       = 5;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_PATTERN_LOW    = 2'd0,
    CFG_PATTERN_HIGH   = 2'd1,
    CFG_PATTERN_LENGTH = 2'd2,
    CFG_ALLOW_BINARY   = 2'd3
  } cfg_addr_t;

  typedef struct packed {
    logic [REG_BYTES-1:0][7:0] pattern;
    logic [LEN_W-1:0]          length;
    logic                      allow_binary;
  } cfg_t;

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= UPPER_FIRST) && (c <= UPPER_LAST);
  endfunction

  function automatic logic fold_equal(input logic [7:0] w, input logic [7:0] p);
    return (w == p)
        || (is_upper(w) && ((w + CASE_OFFSET) == p))
        || (is_upper(p) && ((p + CASE_OFFSET) == w));
  endfunction

endpackage

// ===== sv/case_fold_window_string_matcher.sv =====
// Top level of the case-fold sliding-window string matcher.
`timescale 1ns / 1ps
// One byte per request, one result per request, one request per cycle sustained.
// A request is captured in the input register at its accept edge and is
// evaluated combinationally (window shift, parallel case-folded compare of
// all pattern lanes, line count and binary tracking) into the output register,
// which loads as the input register advances. Both register stages move
// while the output is taken, so backpressure only stalls when the output
// register is held.
// Configuration writes take effect at the next clock edge and belong to idle time.
module case_fold_window_string_matcher
  import cfwsm_pkg::*;
#(
  parameter int MAX_PATTERN = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] data_byte
  input  logic [0:0]            in_tuser,   // [0] start_of_file
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [39:0]           out_tdata,  // [0] match, [32:1] line_number,
                                            // [33] binary_seen, [34] skipped, rest 0
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg;

  cfwsm_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .cfg      (cfg)
  );

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_sof_r;
  logic       s1_adv;

  assign s1_adv    = s1_valid_r && (!out_tvalid || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
      s1_sof_r  <= in_tuser[0];
    end
  end

  // file state
  logic [MAX_PATTERN-1:0][7:0] win_r, win_base, win_shift, win_nxt;
  logic [31:0]                 line_r, line_base, line_nxt;
  logic                        bin_r, bin_base, bin_nxt;
  logic                        ab_r, ab_base, ab_nxt;
  logic                        cmp_hit, hit_nxt;

  always_comb begin
    win_base  = s1_sof_r ? '0 : win_r;
    line_base = s1_sof_r ? 32'd1 : line_r;
    bin_base  = s1_sof_r ? 1'b0 : bin_r;
    ab_base   = s1_sof_r ? 1'b0 : ab_r;

    win_shift[0] = s1_byte_r;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      win_shift[k] = win_base[k-1];
    end
  end

  cfwsm_lane_cmp #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_cmp (
    .win    (win_shift),
    .pattern(cfg.pattern),
    .length (cfg.length),
    .hit    (cmp_hit)
  );

  always_comb begin
    line_nxt = line_base;
    bin_nxt  = bin_base;
    ab_nxt   = ab_base;
    win_nxt  = win_base;
    hit_nxt  = 1'b0;
    if (!ab_base) begin
      if (s1_byte_r == NEWLINE_BYTE && line_base != LINE_MAX) begin
        line_nxt = line_base + 32'd1;
      end
      if (s1_byte_r == BINARY_BYTE) begin
        bin_nxt = 1'b1;
        ab_nxt  = !cfg.allow_binary;
      end
      if (!ab_nxt) begin
        win_nxt = win_shift;
        hit_nxt = cmp_hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= '0;
      line_r <= 32'd1;
      bin_r  <= 1'b0;
      ab_r   <= 1'b0;
    end else if (s1_adv) begin
      win_r  <= win_nxt;
      line_r <= line_nxt;
      bin_r  <= bin_nxt;
      ab_r   <= ab_nxt;
    end
  end

  // output register
  logic        out_valid_r;
  logic [39:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= {5'd0, ab_nxt, bin_nxt, line_nxt, hit_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  a_skip_implies_binary: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tdata[34] || out_tdata[33]))
    else $error("skipped without binary_seen");

  a_no_match_when_skipped: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[34]))
    else $error("match reported on abandoned file");

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[32:1] != 32'd0))
    else $error("line number zero");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_tvalid && !out_tready) |-> !in_tready)
    else $error("input accepted while pipeline full");

  a_abandon_freezes_state: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && ab_r && !s1_sof_r) |=> ($stable(line_r) && $stable(win_r)))
    else $error("state changed on abandoned file");

endmodule

// ===== sv/cfwsm_cfg_regs.sv =====
// Configuration register file: pattern bytes, pattern length, binary policy.
`timescale 1ns / 1ps
module cfwsm_cfg_regs
  import cfwsm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  logic [63:0]      pat_lo_r;
  logic [63:0]      pat_hi_r;
  logic [LEN_W-1:0] len_r;
  logic             allow_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r <= '0;
      pat_hi_r <= '0;
      len_r    <= LEN_W'(1);
      allow_r  <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_addr_t'(cfg_addr))
        CFG_PATTERN_LOW:    pat_lo_r <= cfg_wdata;
        CFG_PATTERN_HIGH:   pat_hi_r <= cfg_wdata;
        CFG_PATTERN_LENGTH: len_r    <= cfg_wdata[LEN_W-1:0];
        CFG_ALLOW_BINARY:   allow_r  <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.pattern      = {pat_hi_r, pat_lo_r};
  assign cfg.length       = len_r;
  assign cfg.allow_binary = allow_r;

endmodule

// ===== sv/cfwsm_lane_cmp.sv =====
// Parallel case-folded compare of the window against the pattern, one lane per byte.
`timescale 1ns / 1ps
module cfwsm_lane_cmp
  import cfwsm_pkg::*;
#(
  parameter int MAX_PATTERN = 16
) (
  input  logic [MAX_PATTERN-1:0][7:0] win,      // index 0 is the newest byte
  input  logic [REG_BYTES-1:0][7:0]   pattern,
  input  logic [LEN_W-1:0]            length,
  output logic                        hit
);

  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam int IW = (LW > 4) ? LW : 4;

  logic [LW-1:0]          eff_len;
  logic [MAX_PATTERN-1:0] lane_ok;

  always_comb begin
    if (length == '0) begin
      eff_len = LW'(1);
    end else if (32'(length) > 32'(MAX_PATTERN)) begin
      eff_len = LW'(MAX_PATTERN);
    end else begin
      eff_len = LW'(length);
    end
  end

  // lane k holds the byte k places back; it meets pattern byte len-1-k
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_lane
    logic [IW-1:0] pidx;
    logic [7:0]    pbyte;
    logic          in_use;

    always_comb begin
      in_use = 32'(k) < 32'(eff_len);
      pidx   = IW'(eff_len) - IW'(k) - IW'(1);
      if ({1'b0, pidx} < (IW + 1)'(REG_BYTES)) begin
        pbyte = pattern[pidx[3:0]];
      end else begin
        pbyte = 8'd0;
      end
      lane_ok[k] = !in_use || fold_equal(win[k], pbyte);
    end
  end

  assign hit = &lane_ok;

endmodule
